[sv/rhht_pkg.sv]
// Shared constants, codes and types for the Robin Hood hash table.
// Depends on nothing; imported by robin_hood_hash_table.
`default_nettype none
package rhht_pkg;
   localparam int INDEX_SLOTS = 64;
   localparam int ENTRY_SLOTS = 48;
   localparam int BW  = $clog2(INDEX_SLOTS);      // bucket address
   localparam int CW  = $clog2(ENTRY_SLOTS + 1);  // entry index / counts
   localparam int EIW = $clog2(ENTRY_SLOTS);      // entry address
   localparam int COUNT_W = 6;

   localparam logic [CW-1:0] NO_ENTRY = '1;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_ABSENT = 2'd1;
   localparam logic [1:0] STS_FULL   = 2'd2;

   localparam logic [4:0] ST_CLEAR   = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_F_START = 5'd2;
   localparam logic [4:0] ST_F_RB    = 5'd3;
   localparam logic [4:0] ST_F_RE    = 5'd4;
   localparam logic [4:0] ST_F_CMP   = 5'd5;
   localparam logic [4:0] ST_ACT     = 5'd6;
   localparam logic [4:0] ST_P_RB    = 5'd7;
   localparam logic [4:0] ST_P_RE    = 5'd8;
   localparam logic [4:0] ST_P_CMP   = 5'd9;
   localparam logic [4:0] ST_B_START = 5'd10;
   localparam logic [4:0] ST_B_RB    = 5'd11;
   localparam logic [4:0] ST_B_RE    = 5'd12;
   localparam logic [4:0] ST_B_CMP   = 5'd13;
   localparam logic [4:0] ST_B_CLR   = 5'd14;
   localparam logic [4:0] ST_B_END   = 5'd15;
   localparam logic [4:0] ST_C_START = 5'd16;
   localparam logic [4:0] ST_C_RD    = 5'd17;
   localparam logic [4:0] ST_C_WR    = 5'd18;
   localparam logic [4:0] ST_C_PH    = 5'd19;
   localparam logic [4:0] ST_C_PL    = 5'd20;
   localparam logic [4:0] ST_DONE    = 5'd21;

   typedef struct packed {
      logic        deleted;
      logic [31:0] value;
      logic [31:0] hash;
      logic [31:0] key;
   } entry_type;
endpackage
`default_nettype wire

[sv/robin_hood_hash_table.sv]
// Robin Hood hash map top level: command FSM, bucket memory and entry memory.
// Depends on rhht_pkg.
`default_nettype none
// Key-value map with Robin Hood probing and backshift removal. One command
// is taken at a time; the response is held in an output register, so the
// next command is accepted while a response waits. Each probe step reads
// the bucket, then the entry, both from synchronous memories. An insert
// then walks its Robin Hood placement until it lands in an empty bucket; a
// removal backshifts the following buckets until one is empty or at home.
// A compaction copies the live entry rows down over the holes, clears all
// 64 buckets and places each live entry again by Robin Hood probing. After
// reset the bucket memory is swept to empty before the first command is
// accepted.
module robin_hood_hash_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,   // lookup_key[31:0], probe_hash[63:32], new_value[95:64]
   input  wire  [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // result_value[31:0], count_now[37:32], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import rhht_pkg::*;

   logic [CW-1:0]  bk_mem [INDEX_SLOTS];
   entry_type      en_mem [ENTRY_SLOTS];

   logic           bk_we;
   logic [BW-1:0]  bk_wa, bk_ra;
   logic [CW-1:0]  bk_wd, bk_rd_ff;
   logic           en_we;
   logic [EIW-1:0] en_wa, en_ra;
   entry_type      en_wd, en_rd_ff;

   logic [4:0]     state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [31:0]    key_ff, key_in, hash_ff, hash_in, val_ff, val_in;
   logic [BW-1:0]  b_ff, b_in, d_ff, d_in, gap_ff, gap_in, clr_ff, clr_in;
   logic [CW-1:0]  idx_ff, idx_in, res_ff, res_in, fe_ff, fe_in;
   logic [CW-1:0]  used_ff, used_in, live_ff, live_in, r_ff, r_in, w_ff, w_in;
   logic           found_ff, found_in, compacting_ff, compacting_in;
   entry_type      row_ff, row_in;
   logic [1:0]     status_ff, status_in;
   logic [31:0]    result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [BW-1:0]  home_gap;
   logic [31:0]    req_hash;

   always_ff @(posedge clock) begin
      if (bk_we) bk_mem[bk_wa] <= bk_wd;
      bk_rd_ff <= bk_mem[bk_ra];
      if (en_we) en_mem[en_wa] <= en_wd;
      en_rd_ff <= en_mem[en_ra];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_value_ff};
   assign req_hash   = (req_tdata[63:32] == '1) ? 32'd0 : req_tdata[63:32];
   assign home_gap   = b_ff - en_rd_ff.hash[BW-1:0];

   always_comb begin
      state_in = state_ff;   cmd_in = cmd_ff;     key_in = key_ff;
      hash_in = hash_ff;     val_in = val_ff;     b_in = b_ff;
      d_in = d_ff;           gap_in = gap_ff;     clr_in = clr_ff;
      idx_in = idx_ff;       res_in = res_ff;     fe_in = fe_ff;
      used_in = used_ff;     live_in = live_ff;   r_in = r_ff;
      w_in = w_ff;           found_in = found_ff; compacting_in = compacting_ff;
      row_in = row_ff;       status_in = status_ff; result_in = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff; rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      bk_we = 1'b0; bk_wa = b_ff; bk_wd = NO_ENTRY; bk_ra = b_ff;
      en_we = 1'b0; en_wa = fe_ff[EIW-1:0]; en_wd = row_ff; en_ra = fe_ff[EIW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            bk_we = 1'b1;
            bk_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BW'(INDEX_SLOTS - 1)) begin
               r_in = '0;
               state_in = compacting_ff ? ST_C_PH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               key_in = req_tdata[31:0];
               hash_in = req_hash;
               val_in = req_tdata[95:64];
               result_in = '0;
               status_in = STS_ABSENT;
               compacting_in = 1'b0;
               case (req_tuser)
                  CMD_LOOKUP, CMD_REMOVE: state_in = ST_F_START;
                  CMD_SET: begin
                     if (used_ff >= CW'(ENTRY_SLOTS) && live_ff < used_ff)
                        state_in = ST_C_START;
                     else
                        state_in = ST_F_START;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_F_START: begin
            b_in = hash_ff[BW-1:0];
            d_in = '0;
            found_in = 1'b0;
            state_in = (live_ff == '0) ? ST_ACT : ST_F_RB;
         end
         ST_F_RB: state_in = ST_F_RE;
         ST_F_RE: begin
            if (bk_rd_ff >= CW'(ENTRY_SLOTS)) begin
               state_in = ST_ACT;
            end else begin
               en_ra = bk_rd_ff[EIW-1:0];
               fe_in = bk_rd_ff;
               state_in = ST_F_CMP;
            end
         end
         ST_F_CMP: begin
            if (d_ff > home_gap) begin
               state_in = ST_ACT;
            end else if (en_rd_ff.hash == hash_ff && en_rd_ff.key == key_ff) begin
               found_in = 1'b1;
               row_in = en_rd_ff;
               state_in = ST_ACT;
            end else begin
               b_in = b_ff + 1'b1;
               d_in = d_ff + 1'b1;
               state_in = ST_F_RB;
            end
         end
         ST_ACT: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (found_ff) begin
                     status_in = STS_OK;
                     result_in = row_ff.value;
                  end
               end
               CMD_SET: begin
                  if (found_ff) begin
                     en_we = 1'b1;
                     en_wd = '{deleted: 1'b0, value: val_ff, hash: row_ff.hash,
                               key: row_ff.key};
                     status_in = STS_OK;
                  end else if (used_ff >= CW'(ENTRY_SLOTS) ||
                               (32'(live_ff) + 32'd1) >= 32'(INDEX_SLOTS)) begin
                     status_in = STS_FULL;
                  end else begin
                     en_we = 1'b1;
                     en_wa = used_ff[EIW-1:0];
                     en_wd = '{deleted: 1'b0, value: val_ff, hash: hash_ff, key: key_ff};
                     idx_in = used_ff;
                     used_in = used_ff + 1'b1;
                     live_in = live_ff + 1'b1;
                     b_in = hash_ff[BW-1:0];
                     d_in = '0;
                     status_in = STS_OK;
                     state_in = ST_P_RB;
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     if ({1'b0, fe_ff} + 1'b1 == {1'b0, used_ff}) begin
                        used_in = used_ff - 1'b1;
                     end else begin
                        en_we = 1'b1;
                        en_wd = row_ff;
                        en_wd.deleted = 1'b1;
                     end
                     live_in = live_ff - 1'b1;
                     if (live_ff == CW'(1)) used_in = '0;
                     gap_in = b_ff;
                     status_in = STS_OK;
                     state_in = ST_B_START;
                  end
               end
               default: ;
            endcase
         end
         ST_P_RB: state_in = ST_P_RE;
         ST_P_RE: begin
            if (bk_rd_ff >= CW'(ENTRY_SLOTS)) begin
               bk_we = 1'b1;
               bk_wd = idx_ff;
               if (compacting_ff) begin
                  r_in = r_ff + 1'b1;
                  state_in = ST_C_PH;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               en_ra = bk_rd_ff[EIW-1:0];
               res_in = bk_rd_ff;
               state_in = ST_P_CMP;
            end
         end
         ST_P_CMP: begin
            // swap with a richer resident and carry it onward
            if (home_gap < d_ff) begin
               bk_we = 1'b1;
               bk_wd = idx_ff;
               idx_in = res_ff;
               d_in = home_gap + 1'b1;
            end else begin
               d_in = d_ff + 1'b1;
            end
            b_in = b_ff + 1'b1;
            state_in = ST_P_RB;
         end
         ST_B_START: begin
            bk_we = 1'b1;
            bk_wa = gap_ff;
            b_in = gap_ff + 1'b1;
            state_in = ST_B_RB;
         end
         ST_B_RB: state_in = ST_B_RE;
         ST_B_RE: begin
            if (bk_rd_ff >= CW'(ENTRY_SLOTS)) begin
               state_in = ST_B_END;
            end else begin
               en_ra = bk_rd_ff[EIW-1:0];
               res_in = bk_rd_ff;
               state_in = ST_B_CMP;
            end
         end
         ST_B_CMP: begin
            if (home_gap == '0) begin
               state_in = ST_B_END;
            end else begin
               bk_we = 1'b1;
               bk_wa = gap_ff;
               bk_wd = res_ff;
               state_in = ST_B_CLR;
            end
         end
         ST_B_CLR: begin
            bk_we = 1'b1;
            gap_in = b_ff;
            b_in = b_ff + 1'b1;
            state_in = ST_B_RB;
         end
         ST_B_END: state_in = (live_ff <= (used_ff >> 2)) ? ST_C_START : ST_DONE;
         ST_C_START: begin
            r_in = '0;
            w_in = '0;
            if (used_ff == live_ff)
               state_in = (cmd_ff == CMD_SET) ? ST_F_START : ST_DONE;
            else
               state_in = ST_C_RD;
         end
         ST_C_RD: begin
            if (r_ff < used_ff) begin
               en_ra = r_ff[EIW-1:0];
               state_in = ST_C_WR;
            end else begin
               used_in = w_ff;
               live_in = w_ff;
               clr_in = '0;
               compacting_in = 1'b1;
               state_in = ST_CLEAR;
            end
         end
         ST_C_WR: begin
            // copy live rows down over the holes
            if (!en_rd_ff.deleted) begin
               en_we = 1'b1;
               en_wa = w_ff[EIW-1:0];
               en_wd = en_rd_ff;
               w_in = w_ff + 1'b1;
            end
            r_in = r_ff + 1'b1;
            state_in = ST_C_RD;
         end
         ST_C_PH: begin
            if (r_ff < used_ff) begin
               en_ra = r_ff[EIW-1:0];
               state_in = ST_C_PL;
            end else begin
               compacting_in = 1'b0;
               state_in = (cmd_ff == CMD_SET) ? ST_F_START : ST_DONE;
            end
         end
         ST_C_PL: begin
            b_in = en_rd_ff.hash[BW-1:0];
            d_in = '0;
            idx_in = r_ff;
            state_in = ST_P_RB;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in = result_ff;
               rsp_count_in = COUNT_W'(live_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         live_ff <= '0;
         compacting_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         live_ff <= live_in;
         compacting_ff <= compacting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;       key_ff <= key_in;       hash_ff <= hash_in;
      val_ff <= val_in;       b_ff <= b_in;           d_ff <= d_in;
      gap_ff <= gap_in;       idx_ff <= idx_in;       res_ff <= res_in;
      fe_ff <= fe_in;         r_ff <= r_in;           w_ff <= w_in;
      found_ff <= found_in;   row_ff <= row_in;       status_ff <= status_in;
      result_ff <= result_in; rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in; rsp_count_ff <= rsp_count_in;
   end
endmodule
`default_nettype wire

[tb/sv/robin_hood_hash_table_tb.sv]
// Self-checking bench for robin_hood_hash_table: directed table, then random traffic.
// Depends on rhht_pkg and robin_hood_hash_table; predicts every response in-bench.
`default_nettype none
module robin_hood_hash_table_tb;
   import rhht_pkg::*;

   localparam int WATCHDOG = 20000;
   localparam int NUM_RANDOM = 600;
   localparam int EMPTY = 'hFF;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  command;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] value;
      bit          typed;
      logic [1:0]  status;
      logic [31:0] result;
      logic [5:0]  count;
   } stim_row_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] result;
      logic [5:0]  count;
   } rsp_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tready = 0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [39:0] rsp_tdata;
   wire  [1:0]  rsp_tuser;

   robin_hood_hash_table u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // predictor copy of the map
   int          buckets[INDEX_SLOTS];
   logic [31:0] ent_key[ENTRY_SLOTS];
   logic [31:0] ent_hash[ENTRY_SLOTS];
   logic [31:0] ent_val[ENTRY_SLOTS];
   bit          ent_del[ENTRY_SLOTS];
   int          used_rows;
   int          live;

   rsp_item_type pending_rsp[$];
   logic [31:0] known_keys[$];
   logic [31:0] known_hashes[$];
   int          failures = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          all_sent = 0;

   function automatic int home(logic [31:0] h);
      return int'(h[BW-1:0]);
   endfunction

   function automatic int probe_dist(logic [31:0] h, int b);
      return (b - home(h)) & (INDEX_SLOTS - 1);
   endfunction

   function automatic logic [31:0] hash_at(int b);
      int e;
      e = buckets[b];
      return (e != EMPTY) ? ent_hash[e] : 32'd0;
   endfunction

   function automatic void rh_place(int idx, logic [31:0] h);
      int b, d, res, rd;
      b = home(h);
      d = 0;
      for (int s = 0; s < INDEX_SLOTS; s++) begin
         res = buckets[b];
         if (res == EMPTY) begin
            buckets[b] = idx;
            return;
         end
         rd = probe_dist(hash_at(b), b);
         if (rd < d) begin
            buckets[b] = idx;
            idx = res;
            d = rd;
         end
         b = (b + 1) & (INDEX_SLOTS - 1);
         d++;
      end
   endfunction

   function automatic bit probe_key(logic [31:0] key, logic [31:0] h, output int bkt);
      int b, d, e;
      b = home(h);
      d = 0;
      bkt = 0;
      if (live == 0) return 0;
      for (int s = 0; s < INDEX_SLOTS; s++) begin
         e = buckets[b];
         if (e == EMPTY) return 0;
         if (d > probe_dist(ent_hash[e], b)) return 0;
         if (ent_hash[e] == h && ent_key[e] == key) begin
            bkt = b;
            return 1;
         end
         b = (b + 1) & (INDEX_SLOTS - 1);
         d++;
      end
      return 0;
   endfunction

   function automatic void shift_back(int gap);
      int cur, e;
      cur = (gap + 1) & (INDEX_SLOTS - 1);
      buckets[gap] = EMPTY;
      for (int s = 0; s < INDEX_SLOTS; s++) begin
         e = buckets[cur];
         if (e == EMPTY || probe_dist(hash_at(cur), cur) == 0) return;
         buckets[gap] = e;
         buckets[cur] = EMPTY;
         gap = cur;
         cur = (cur + 1) & (INDEX_SLOTS - 1);
      end
   endfunction

   function automatic void compact_rows();
      int w;
      w = 0;
      if (used_rows == live) return;
      for (int r = 0; r < used_rows; r++) begin
         if (!ent_del[r]) begin
            ent_key[w] = ent_key[r];
            ent_hash[w] = ent_hash[r];
            ent_val[w] = ent_val[r];
            ent_del[w] = 0;
            w++;
         end
      end
      used_rows = w;
      live = w;
      foreach (buckets[i]) buckets[i] = EMPTY;
      for (int r = 0; r < w; r++) rh_place(r, ent_hash[r]);
   endfunction

   function automatic rsp_item_type map_command(logic [1:0] cmd, logic [31:0] key,
                                                logic [31:0] h_in, logic [31:0] val);
      rsp_item_type r;
      logic [31:0] h;
      int b, e;
      h = (h_in == '1) ? 32'd0 : h_in;
      r.status = STS_ABSENT;
      r.result = '0;
      if (cmd == CMD_LOOKUP) begin
         if (probe_key(key, h, b)) begin
            r.status = STS_OK;
            r.result = ent_val[buckets[b]];
         end
      end else if (cmd == CMD_SET) begin
         if (used_rows >= ENTRY_SLOTS && live < used_rows) compact_rows();
         if (probe_key(key, h, b)) begin
            ent_val[buckets[b]] = val;
            r.status = STS_OK;
         end else if (used_rows >= ENTRY_SLOTS || live + 1 >= INDEX_SLOTS) begin
            r.status = STS_FULL;
         end else begin
            ent_key[used_rows] = key;
            ent_hash[used_rows] = h;
            ent_val[used_rows] = val;
            ent_del[used_rows] = 0;
            used_rows++;
            live++;
            rh_place(used_rows - 1, h);
            r.status = STS_OK;
         end
      end else if (cmd == CMD_REMOVE) begin
         if (probe_key(key, h, b)) begin
            e = buckets[b];
            if (e + 1 == used_rows) used_rows--;
            else ent_del[e] = 1;
            live--;
            if (live == 0) used_rows = 0;
            shift_back(b);
            if (live <= used_rows / 4) compact_rows();
            r.status = STS_OK;
         end
      end
      r.count = live[5:0];
      return r;
   endfunction

   // hold valid high across back-to-back transfers; drop it while idling
   task automatic send_command(logic [1:0] cmd, logic [31:0] key, logic [31:0] h,
                               logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {val, h, key};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(map_command(cmd, key, h, val));
   endtask

   task automatic drain_responses();
      req_tvalid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no command outstanding");
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[31:0] != want.result) begin
               $error("result_value: expected %h actual %h", want.result, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[37:32] != want.count) begin
               $error("count_now: expected %0d actual %0d", want.count, rsp_tdata[37:32]);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !(all_sent && pending_rsp.size() == 0)) begin
         $display("FAIL");
         $finish;
      end
   end

   stim_row_type directed[$];

   function automatic stim_row_type row(logic [1:0] c, logic [31:0] k, logic [31:0] h,
                                        logic [31:0] v, bit t = 0, logic [1:0] s = 0,
                                        logic [31:0] res = 0, logic [5:0] n = 0);
      stim_row_type r;
      r.command = c; r.key = k; r.hash = h; r.value = v;
      r.typed = t; r.status = s; r.result = res; r.count = n;
      return r;
   endfunction

   initial begin
      logic [1:0]  cmd;
      logic [31:0] key, h, val;
      int pick, sel;
      rsp_item_type got;

      foreach (buckets[i]) buckets[i] = EMPTY;
      used_rows = 0;
      live = 0;

      // empty-map lookup, unused command, all-ones hash, extremes, clashes
      directed.push_back(row(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 1, STS_ABSENT, 0, 0));
      directed.push_back(row(CMD_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1, STS_ABSENT, 0, 0));
      directed.push_back(row(CMD_UNUSED, 32'hFFFFFFFF, 32'h5, 32'hFFFFFFFF, 1, STS_ABSENT,
                             0, 0));
      directed.push_back(row(CMD_SET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                             1, STS_OK, 0, 1));
      directed.push_back(row(CMD_LOOKUP, 32'hFFFFFFFF, 32'h0, 0, 1, STS_OK, 32'hFFFFFFFF, 1));
      directed.push_back(row(CMD_SET, 32'h0, 32'h0, 32'h0, 1, STS_OK, 0, 2));
      directed.push_back(row(CMD_SET, 32'h1, 32'h40, 32'h11, 1, STS_OK, 0, 3));
      directed.push_back(row(CMD_SET, 32'h2, 32'h3F, 32'h22, 1, STS_OK, 0, 4));
      directed.push_back(row(CMD_SET, 32'h3, 32'hFFFFFFC1, 32'h33, 1, STS_OK, 0, 5));
      directed.push_back(row(CMD_SET, 32'h1, 32'h40, 32'hAAAA5555, 1, STS_OK, 0, 5));
      directed.push_back(row(CMD_LOOKUP, 32'h1, 32'h40, 0, 1, STS_OK, 32'hAAAA5555, 5));
      directed.push_back(row(CMD_LOOKUP, 32'h1, 32'h41, 0));
      directed.push_back(row(CMD_REMOVE, 32'h0, 32'h0, 0));
      directed.push_back(row(CMD_LOOKUP, 32'h1, 32'h40, 0));
      directed.push_back(row(CMD_REMOVE, 32'h3, 32'hFFFFFFC1, 0));
      directed.push_back(row(CMD_REMOVE, 32'h3, 32'hFFFFFFC1, 0));
      directed.push_back(row(CMD_REMOVE, 32'hFFFFFFFF, 32'h0, 0));
      directed.push_back(row(CMD_REMOVE, 32'h2, 32'h3F, 0));
      directed.push_back(row(CMD_REMOVE, 32'h1, 32'h40, 0, 1, STS_OK, 0, 0));
      directed.push_back(row(CMD_LOOKUP, 32'h1, 32'h40, 0, 1, STS_ABSENT, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 0;

      foreach (directed[i]) begin
         send_command(directed[i].command, directed[i].key, directed[i].hash,
                      directed[i].value);
         if (directed[i].typed) begin
            got = pending_rsp[$];
            if (got.status != directed[i].status || got.result != directed[i].result ||
                got.count != directed[i].count) begin
               $error("directed row %0d: typed expectation disagrees with prediction", i);
               failures++;
            end
         end
      end
      // hold the sender until every response is back
      drain_responses();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         for (int n = 0; n < NUM_RANDOM / 4; n++) begin
            sel = $urandom_range(99);
            // few keys with colliding hashes so probing, fill and compaction happen
            if (known_keys.size() > 0 && sel < 70) begin
               pick = $urandom_range(known_keys.size() - 1);
               key = known_keys[pick];
               h = known_hashes[pick];
            end else begin
               key = (sel < 90) ? $urandom_range(255) : $urandom;
               h = (sel < 85) ? {$urandom_range(7) == 0 ? 26'h3FFFFFF : 26'($urandom),
                                 6'($urandom_range(7))} : $urandom;
               if (sel == 99) h = '1;
               known_keys.push_back(key);
               known_hashes.push_back(h);
            end
            sel = $urandom_range(99);
            if (phase % 2 == 0) cmd = (sel < 55) ? CMD_SET : (sel < 75) ? CMD_LOOKUP :
                                      (sel < 98) ? CMD_REMOVE : CMD_UNUSED;
            else cmd = (sel < 35) ? CMD_SET : (sel < 60) ? CMD_LOOKUP :
                       (sel < 98) ? CMD_REMOVE : CMD_UNUSED;
            val = $urandom;
            send_command(cmd, key, h, val);
         end
         drain_responses();
      end

      all_sent = 1;
      repeat (300) @(posedge clock);
      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
